>>> src/fprs_pkg.sv
// ----------------------------------------------------------------------------
// fprs_pkg
// Types and constants shared by the finder pattern run ratio scanner files.
// ----------------------------------------------------------------------------
package fprs_pkg;

  // run length counters saturate at the top of their range
  localparam int unsigned RUN_W     = 13;
  localparam int unsigned SEG_W     = 12;
  localparam int unsigned TOL_W     = 7;
  localparam int unsigned NUM_RUNS  = 5;
  localparam int unsigned RVC_W     = 3;

  typedef logic [RUN_W-1:0] run_len_t;
  typedef logic [SEG_W-1:0] seg_pos_t;
  typedef logic [TOL_W-1:0] tol_t;
  typedef logic [RVC_W-1:0] run_cnt_t;

  localparam run_len_t RUN_MAX   = '1;
  localparam tol_t     TOL_RESET = TOL_W'(50);
  localparam run_cnt_t RUNS_FULL = RVC_W'(NUM_RUNS);

endpackage

>>> src/fprs_cfg_if.sv
// ----------------------------------------------------------------------------
// fprs_cfg_if
// Write channel for the tolerance register.
// ----------------------------------------------------------------------------
interface fprs_cfg_if;
  import fprs_pkg::*;

  logic valid;
  logic ready;
  tol_t tolerance_percent;

  modport source (output valid, output tolerance_percent, input ready);
  modport sink   (input valid, input tolerance_percent, output ready);
endinterface

>>> src/fprs_pix_if.sv
// ----------------------------------------------------------------------------
// fprs_pix_if
// Pixel channel: one binarized pixel per word with an end of line flag.
// ----------------------------------------------------------------------------
interface fprs_pix_if;
  logic valid;
  logic ready;
  logic is_white;
  logic last_in_line;

  modport source (output valid, output is_white, output last_in_line, input ready);
  modport sink   (input valid, input is_white, input last_in_line, output ready);
endinterface

>>> src/fprs_seg_if.sv
// ----------------------------------------------------------------------------
// fprs_seg_if
// Result channel: begin and end position of the middle black run.
// ----------------------------------------------------------------------------
interface fprs_seg_if;
  import fprs_pkg::*;

  logic     valid;
  logic     ready;
  seg_pos_t seg_begin;
  seg_pos_t seg_end;

  modport source (output valid, output seg_begin, output seg_end, input ready);
  modport sink   (input valid, input seg_begin, input seg_end, output ready);
endinterface

>>> src/finder_pattern_run_ratio_scanner_top.sv
// ----------------------------------------------------------------------------
// finder_pattern_run_ratio_scanner_top
// Scan line detector for the 1:1:3:1:1 finder pattern of a QR symbol.
// ----------------------------------------------------------------------------
// The block takes one binarized pixel per clock while pixel ready is high and
// tracks the last five color runs of the line. When a white pixel closes a
// black run and the runs black,white,black,white,black (the first one preceded
// by white) fit 1:1:3:1:1 within tolerance_percent, the begin and end
// positions of the middle black run go to the output register, or to the skid
// entry while the output waits. The run registers are updated and the ratio
// test is evaluated in the same cycle, so a pixel can be accepted on every
// clock while pixel ready is high. A two entry output buffer lets the pixel
// side keep going while a result waits; pixel ready drops only when both
// entries are full. Positions saturate at MAX_LINE_WIDTH-1 and are reported
// modulo 4096. Write the tolerance only while no pixel is in flight.
// ----------------------------------------------------------------------------
module finder_pattern_run_ratio_scanner_top #(
  parameter int unsigned MAX_LINE_WIDTH = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fprs_cfg_if.sink   cfg_i,
  fprs_pix_if.sink   pix_i,
  fprs_seg_if.source seg_o
);
  import fprs_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_LINE_WIDTH);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LINE_WIDTH - 1);

  typedef logic signed [25:0] prod_t;
  localparam prod_t K100 = 26'sd100;
  localparam prod_t K3   = 26'sd3;

  tol_t             tol_q;
  run_len_t         runs_q [NUM_RUNS];
  run_len_t         runs_d [NUM_RUNS];
  logic [POS_W-1:0] pos_q, pos_d;
  logic             prev_q, prev_d;
  run_cnt_t         rvc_q, rvc_d;
  logic             fraw_q, fraw_d;

  logic             out_vld_q, out_vld_d;
  seg_pos_t         out_beg_q, out_beg_d, out_end_q, out_end_d;
  logic             skid_vld_q, skid_vld_d;
  seg_pos_t         skid_beg_q, skid_beg_d, skid_end_q, skid_end_d;

  logic             in_fire;
  logic             match;
  logic             fits;
  seg_pos_t         pos12, new_beg, new_end;
  prod_t            lo, hi, lo3, hi3;
  prod_t            x0, x1, x2, x3, x4;
  prod_t            a0, a2;

  assign cfg_i.ready = 1'b1;
  assign pix_i.ready = !skid_vld_q;
  assign in_fire     = pix_i.valid && !skid_vld_q;

  // exact cross-multiplied ratio bounds, lower bounds may go negative
  always_comb begin
    lo  = K100 - prod_t'(tol_q);
    hi  = K100 + prod_t'(tol_q);
    lo3 = K3 * lo;
    hi3 = K3 * hi;
    x0  = prod_t'(runs_q[0]);
    x1  = prod_t'(runs_q[1]);
    x2  = prod_t'(runs_q[2]);
    x3  = prod_t'(runs_q[3]);
    x4  = prod_t'(runs_q[4]);
    a0  = K100 * x0;
    a2  = K100 * x2;
    fits = (a0 > lo * x1) && (a0 < hi * x1) &&
           (a0 > lo * x3) && (a0 < hi * x3) &&
           (a0 > lo * x4) && (a0 < hi * x4) &&
           (a2 > lo3 * x0) && (a2 < hi3 * x0);
  end

  always_comb begin
    pos12   = SEG_W'(pos_q);
    new_beg = pos12 - runs_q[4][SEG_W-1:0] - runs_q[3][SEG_W-1:0]
                    - runs_q[2][SEG_W-1:0];
    new_end = pos12 - runs_q[4][SEG_W-1:0] - runs_q[3][SEG_W-1:0] - SEG_W'(1);
  end

  // run tracking
  always_comb begin
    runs_d = runs_q;
    pos_d  = pos_q;
    prev_d = prev_q;
    rvc_d  = rvc_q;
    fraw_d = fraw_q;
    match  = 1'b0;
    if (in_fire) begin
      if (pos_q == '0) begin
        // fresh history at line start
        for (int i = 0; i < NUM_RUNS - 1; i++) begin
          runs_d[i] = '0;
        end
        runs_d[NUM_RUNS-1] = RUN_W'(1);
        prev_d = pix_i.is_white;
        fraw_d = pix_i.is_white;
        rvc_d  = '0;
      end else if (pix_i.is_white == prev_q) begin
        if (runs_q[NUM_RUNS-1] != RUN_MAX) begin
          runs_d[NUM_RUNS-1] = runs_q[NUM_RUNS-1] + RUN_W'(1);
        end
      end else begin
        for (int i = 0; i < NUM_RUNS - 1; i++) begin
          runs_d[i] = runs_q[i+1];
        end
        runs_d[NUM_RUNS-1] = RUN_W'(1);
        if (pix_i.is_white) begin
          // white closes a black run
          match = (rvc_q == RUNS_FULL) && fits;
          if (rvc_q != '0 && rvc_q < RUNS_FULL) begin
            rvc_d = rvc_q + RVC_W'(1);
          end
          prev_d = 1'b1;
          fraw_d = 1'b1;
        end else begin
          if (rvc_q == '0) begin
            if (fraw_q) begin
              rvc_d = RVC_W'(1);
            end
          end else if (rvc_q < RUNS_FULL) begin
            rvc_d = rvc_q + RVC_W'(1);
          end
          prev_d = 1'b0;
        end
      end
      if (pix_i.last_in_line) begin
        pos_d = '0;
      end else if (pos_q < POS_LAST) begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  // output register plus skid entry
  always_comb begin
    out_vld_d  = out_vld_q;
    out_beg_d  = out_beg_q;
    out_end_d  = out_end_q;
    skid_vld_d = skid_vld_q;
    skid_beg_d = skid_beg_q;
    skid_end_d = skid_end_q;
    if (!out_vld_q || seg_o.ready) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_beg_d  = skid_beg_q;
        out_end_d  = skid_end_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = match;
        out_beg_d = new_beg;
        out_end_d = new_end;
      end
    end else if (match) begin
      skid_vld_d = 1'b1;
      skid_beg_d = new_beg;
      skid_end_d = new_end;
    end
  end

  assign seg_o.valid     = out_vld_q;
  assign seg_o.seg_begin = out_beg_q;
  assign seg_o.seg_end   = out_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q      <= TOL_RESET;
      for (int i = 0; i < NUM_RUNS; i++) begin
        runs_q[i] <= '0;
      end
      pos_q      <= '0;
      prev_q     <= 1'b0;
      rvc_q      <= '0;
      fraw_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        tol_q <= cfg_i.tolerance_percent;
      end
      runs_q     <= runs_d;
      pos_q      <= pos_d;
      prev_q     <= prev_d;
      rvc_q      <= rvc_d;
      fraw_q     <= fraw_d;
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_beg_q  <= out_beg_d;
    out_end_q  <= out_end_d;
    skid_beg_q <= skid_beg_d;
    skid_end_q <= skid_end_d;
  end

endmodule
